/* rtl/lsm_pkg.sv */
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the latency statistics monitor
// Holds the item and result structs, status codes, the sequencer states and
// the sizes of the per-channel timestamp rings.
// ----------------------------------------------------------------------------
package lsm_pkg;

	// Channel and ring sizes.
	localparam int RING_DEPTH    = 64;
	localparam int CHANNEL_COUNT = 5;
	localparam int PTR_W         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int LVL_W         = $clog2(RING_DEPTH + 1);
	localparam int CH_IDX_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int MEM_DEPTH     = CHANNEL_COUNT * RING_DEPTH;
	localparam int ADDR_W        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Configuration register.
	localparam int MASK_W = 5;
	localparam logic [MASK_W-1:0] MASK_RESET = 5'd8;

	// Data widths.
	localparam int DATA_W = 32;
	localparam int DIV_CNT_W = $clog2(DATA_W);

	// Command codes.
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_END   = 1'b1;

	typedef enum logic [2:0] {
		ST_START_OK   = 3'd0,
		ST_START_FULL = 3'd1,
		ST_END_OK     = 3'd2,
		ST_END_EMPTY  = 3'd3,
		ST_END_ZERO   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FETCH,
		S_DIVIDE
	} state_t;

	typedef struct packed {
		logic              command;
		logic [2:0]        channel;
		logic [DATA_W-1:0] timestamp;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] duration;
		logic [DATA_W-1:0] total_time;
		logic [DATA_W-1:0] average_time;
		logic [DATA_W-1:0] maximum_time;
		logic [DATA_W-1:0] minimum_time;
		logic [DATA_W-1:0] event_count;
	} result_t;

endpackage

/* rtl/latency_stats_monitor.sv */
// ----------------------------------------------------------------------------
// latency_stats_monitor: per-channel start/end latency statistics
// Keeps a ring of start timestamps per channel and, on an end that pops a
// non-zero stamp, updates total, max, min, event count and average latency.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are accepted on a rising edge with start high and busy
//   low; item carries command, channel and timestamp. Each transaction gives
//   exactly one result, shown on result for one cycle with done high. The
//   receiver cannot stall; the result register frees the next acceptance.
//   A start item or an end on an empty ring gives its result from the decode
//   state; an end item that pops a stamp also passes through the registered
//   ring read and, when the stamp and the count are both non-zero, through
//   the bit-serial divider that forms the average. Busy stays high until the
//   result is written.
//   count_at_end_mask is written on cfg_valid and cfg_ready (always ready);
//   write it only while the block is idle, which the block does not enforce.
//   Reset clears all ring pointers, fill levels, totals, maxima, averages and
//   counts, sets minima to all ones and the mask to 8. Ring contents are not
//   cleared; only entries written by an earlier start are ever read.
// ----------------------------------------------------------------------------
module latency_stats_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lsm_pkg::item_t                item,
	output logic                          done,
	output lsm_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lsm_pkg::MASK_W-1:0]    cfg_data
);
	import lsm_pkg::*;

	// Sequencer and configuration.
	state_t state_q, state_d;
	logic [MASK_W-1:0] mask_q;
	logic done_q;

	// Per-channel state.
	logic [PTR_W-1:0]  wr_ptr_q [CHANNEL_COUNT];
	logic [PTR_W-1:0]  rd_ptr_q [CHANNEL_COUNT];
	logic [LVL_W-1:0]  level_q  [CHANNEL_COUNT];
	logic [DATA_W-1:0] total_q  [CHANNEL_COUNT];
	logic [DATA_W-1:0] max_q    [CHANNEL_COUNT];
	logic [DATA_W-1:0] min_q    [CHANNEL_COUNT];
	logic [DATA_W-1:0] mean_q   [CHANNEL_COUNT];
	logic [DATA_W-1:0] count_q  [CHANNEL_COUNT];

	// Transaction payload and divider.
	item_t             item_q;
	result_t           result_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] divisor_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Timestamp memory.
	logic [DATA_W-1:0] stamp_mem [MEM_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	// Decoded item fields.
	logic [CH_IDX_W-1:0] ch_idx;
	logic                in_range;
	logic                at_end;
	logic                ring_full;
	logic                ring_empty;
	logic [PTR_W-1:0]    wr_ptr_next, rd_ptr_next;

	// End-path arithmetic.
	logic [DATA_W-1:0] dur_calc;
	logic [DATA_W-1:0] total_new;
	logic [DATA_W-1:0] count_new;
	logic [DATA_W-1:0] max_new;
	logic [DATA_W-1:0] min_new;

	// Divider step.
	logic [DATA_W:0]   div_shift;
	logic [DATA_W:0]   div_diff;
	logic [DATA_W-1:0] rem_next;
	logic [DATA_W-1:0] quo_next;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	// Channel decode.
	assign ch_idx     = CH_IDX_W'(item_q.channel);
	assign in_range   = int'(item_q.channel) < CHANNEL_COUNT;
	assign at_end     = in_range && (int'(item_q.channel) < MASK_W) &&
		mask_q[item_q.channel];
	assign ring_full  = level_q[ch_idx] >= LVL_W'(RING_DEPTH);
	assign ring_empty = level_q[ch_idx] == '0;
	assign wr_ptr_next = (wr_ptr_q[ch_idx] == PTR_W'(RING_DEPTH - 1)) ? '0 :
		wr_ptr_q[ch_idx] + PTR_W'(1);
	assign rd_ptr_next = (rd_ptr_q[ch_idx] == PTR_W'(RING_DEPTH - 1)) ? '0 :
		rd_ptr_q[ch_idx] + PTR_W'(1);
	assign wr_addr = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH) + ADDR_W'(wr_ptr_q[ch_idx]);
	assign rd_addr = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH) + ADDR_W'(rd_ptr_q[ch_idx]);

	// Statistics update for a recorded end.
	assign dur_calc  = item_q.timestamp - rd_data_q;
	assign total_new = total_q[ch_idx] + dur_calc;
	assign count_new = count_q[ch_idx] + (at_end ? DATA_W'(1) : '0);
	assign max_new   = (dur_calc > max_q[ch_idx]) ? dur_calc : max_q[ch_idx];
	assign min_new   = (dur_calc < min_q[ch_idx]) ? dur_calc : min_q[ch_idx];

	// One restoring division step per cycle.
	assign div_shift = {rem_q, quo_q[DATA_W-1]};
	assign div_diff  = div_shift - {1'b0, divisor_q};
	assign rem_next  = div_diff[DATA_W] ? div_shift[DATA_W-1:0] : div_diff[DATA_W-1:0];
	assign quo_next  = {quo_q[DATA_W-2:0], ~div_diff[DATA_W]};

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory strobes.
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (in_range) begin
					if (item_q.command == CMD_START) begin
						mem_we = !ring_full;
					end else if (!ring_empty) begin
						mem_re  = 1'b1;
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				state_d = S_IDLE;
				if (rd_data_q != '0 && count_new != '0) begin
					state_d = S_DIVIDE;
				end
			end
			S_DIVIDE: begin
				if (div_cnt_q == '0) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	// Channel state and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				wr_ptr_q[c] <= '0;
				rd_ptr_q[c] <= '0;
				level_q[c]  <= '0;
				total_q[c]  <= '0;
				max_q[c]    <= '0;
				min_q[c]    <= '1;
				mean_q[c]   <= '0;
				count_q[c]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_DECODE: begin
					if (!in_range) begin
						done_q <= 1'b1;
					end else if (item_q.command == CMD_START) begin
						done_q <= 1'b1;
						if (!ring_full) begin
							wr_ptr_q[ch_idx] <= wr_ptr_next;
							level_q[ch_idx]  <= level_q[ch_idx] + LVL_W'(1);
						end
						if (!at_end) begin
							count_q[ch_idx] <= count_q[ch_idx] + DATA_W'(1);
						end
					end else if (ring_empty) begin
						done_q <= 1'b1;
					end else begin
						rd_ptr_q[ch_idx] <= rd_ptr_next;
						level_q[ch_idx]  <= level_q[ch_idx] - LVL_W'(1);
					end
				end
				S_FETCH: begin
					if (rd_data_q == '0) begin
						done_q <= 1'b1;
					end else begin
						total_q[ch_idx] <= total_new;
						count_q[ch_idx] <= count_new;
						max_q[ch_idx]   <= max_new;
						min_q[ch_idx]   <= min_new;
						if (count_new == '0) begin
							mean_q[ch_idx] <= '0;
							done_q         <= 1'b1;
						end
					end
				end
				S_DIVIDE: begin
					if (div_cnt_q == '0) begin
						mean_q[ch_idx] <= quo_next;
						done_q         <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item capture, divider registers and result assembly.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					item_q <= item;
				end
			end
			S_DECODE: begin
				result_q.duration     <= '0;
				result_q.total_time   <= total_q[ch_idx];
				result_q.average_time <= mean_q[ch_idx];
				result_q.maximum_time <= max_q[ch_idx];
				result_q.minimum_time <= min_q[ch_idx];
				result_q.event_count  <= count_q[ch_idx];
				if (!in_range) begin
					result_q.status <= (item_q.command == CMD_END) ? ST_END_EMPTY :
						ST_START_FULL;
					result_q.total_time   <= '0;
					result_q.average_time <= '0;
					result_q.maximum_time <= '0;
					result_q.minimum_time <= '1;
					result_q.event_count  <= '0;
				end else if (item_q.command == CMD_START) begin
					result_q.status <= ring_full ? ST_START_FULL : ST_START_OK;
					if (!at_end) begin
						result_q.event_count <= count_q[ch_idx] + DATA_W'(1);
					end
				end else begin
					result_q.status <= ST_END_EMPTY;
				end
			end
			S_FETCH: begin
				if (rd_data_q == '0) begin
					result_q.status <= ST_END_ZERO;
				end else begin
					result_q.status       <= ST_END_OK;
					result_q.duration     <= dur_calc;
					result_q.total_time   <= total_new;
					result_q.average_time <= '0;
					result_q.maximum_time <= max_new;
					result_q.minimum_time <= min_new;
					result_q.event_count  <= count_new;
				end
				rem_q     <= '0;
				quo_q     <= total_new;
				divisor_q <= count_new;
				div_cnt_q <= DIV_CNT_W'(DATA_W - 1);
			end
			S_DIVIDE: begin
				rem_q     <= rem_next;
				quo_q     <= quo_next;
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
				if (div_cnt_q == '0) begin
					result_q.average_time <= quo_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Timestamp memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[wr_addr] <= item_q.timestamp;
		end
		if (mem_re) begin
			rd_data_q <= stamp_mem[rd_addr];
		end
	end

endmodule
